FILE: hw/rtl/sss_pkg.sv
// Package: shared constants, types and command/status structs for set statistics.
package sss_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W       = 32 + CNT_W;
   localparam int OUT_CNT_W   = 11;
   localparam int DIV_STEPS   = SUM_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_RD_A,
      ST_SORT_RD_B,
      ST_SORT_CMP,
      ST_SORT_WR_B,
      ST_MED_RD,
      ST_MED_WAIT,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic take_sample;   // accept one sample transaction
      logic pass_init;     // start a new sort pass
      logic pass_next;     // advance pair index
      logic rd_a;          // capture element at pair index
      logic rd_b;          // read element at pair index + 1
      logic cmp_wr_a;      // compare and write low element if swapped
      logic wr_b;          // write high element if swapped
      logic med_rd;        // read median address
      logic med_cap;       // capture median and start divider
      logic div_step;      // one restoring divide step
      logic set_clear;     // clear set state after result
   } cmd_type;

   typedef struct packed {
      logic pair_none;     // pair at current index falls outside the set
      logic pair_last;     // no further pair in this pass
      logic pass_last;     // final pass done
      logic div_done;      // divider finished
   } status_type;

endpackage

FILE: hw/rtl/sss_datapath.sv
// Datapath: sample memory, running min/max/sum, sort pairs, divider.
module sss_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  sss_pkg::cmd_type               cmd,
   output sss_pkg::status_type            status,
   input  logic signed [31:0]             sample,
   output logic signed [31:0]             min_value,
   output logic signed [31:0]             max_value,
   output logic signed [31:0]             mean_value,
   output logic signed [31:0]             median_value,
   output logic [sss_pkg::OUT_CNT_W-1:0]  sample_count,
   output logic                           overflow
);

   logic signed [31:0] mem [sss_pkg::MAX_SAMPLES];
   logic signed [31:0] rd_data_ff;

   logic [sss_pkg::CNT_W-1:0]  count_ff, count_in;
   logic signed [31:0]         min_ff, min_in, max_ff, max_in;
   logic signed [sss_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic                       drop_ff, drop_in;
   logic [sss_pkg::CNT_W-1:0]  pass_ff, pass_in;
   logic [sss_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic signed [31:0]         a_ff, a_in;
   logic                       swap_ff, swap_in;
   logic signed [31:0]         med_ff;
   logic [sss_pkg::SUM_W-1:0]  quo_ff, quo_in;
   logic [sss_pkg::CNT_W:0]    rem_ff, rem_in;
   logic                       neg_ff;
   logic [sss_pkg::DIV_CNT_W-1:0] dcnt_ff, dcnt_in;

   logic                       full;
   logic [sss_pkg::ADDR_W-1:0] wr_addr, rd_addr;
   logic signed [31:0]         wr_data;
   logic                       wr_en;
   logic [sss_pkg::CNT_W-1:0]  idx_b;
   logic [sss_pkg::CNT_W:0]    rem_sh, rem_sub;
   logic [sss_pkg::SUM_W-1:0]  sum_abs;
   logic signed [sss_pkg::SUM_W-1:0] quo_s;

   assign full    = (count_ff == sss_pkg::CNT_W'(sss_pkg::MAX_SAMPLES));
   assign idx_b   = idx_ff + sss_pkg::CNT_W'(1);
   assign sum_abs = sum_ff[sss_pkg::SUM_W-1] ? sss_pkg::SUM_W'(-sum_ff) : sum_ff;

   // Memory address and write mux.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[sss_pkg::ADDR_W-1:0];
      wr_data = sample;
      rd_addr = idx_ff[sss_pkg::ADDR_W-1:0];
      if (cmd.take_sample && !full) begin
         wr_en = 1'b1;
      end else if (cmd.cmp_wr_a) begin
         wr_en   = rd_data_ff < a_ff;
         wr_addr = idx_ff[sss_pkg::ADDR_W-1:0];
         wr_data = rd_data_ff;
      end else if (cmd.wr_b) begin
         wr_en   = swap_ff;
         wr_addr = idx_b[sss_pkg::ADDR_W-1:0];
         wr_data = a_ff;
      end
      if (cmd.rd_b) begin
         rd_addr = idx_b[sss_pkg::ADDR_W-1:0];
      end else if (cmd.med_rd) begin
         rd_addr = count_ff[sss_pkg::ADDR_W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Running statistics and sort control.
   always_comb begin
      count_in = count_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      drop_in  = drop_ff;
      pass_in  = pass_ff;
      idx_in   = idx_ff;
      a_in     = a_ff;
      swap_in  = swap_ff;
      if (cmd.take_sample) begin
         if (full) begin
            drop_in = 1'b1;
         end else begin
            count_in = count_ff + sss_pkg::CNT_W'(1);
            sum_in   = sum_ff + sss_pkg::SUM_W'(sample);
            min_in   = (count_ff == '0 || sample < min_ff) ? sample : min_ff;
            max_in   = (count_ff == '0 || sample > max_ff) ? sample : max_ff;
         end
      end
      if (cmd.pass_init) begin
         pass_in = '0;
         idx_in  = '0;
      end
      if (cmd.pass_next) begin
         if (status.pair_last) begin
            pass_in = pass_ff + sss_pkg::CNT_W'(1);
            idx_in  = {{(sss_pkg::CNT_W-1){1'b0}}, ~pass_ff[0]};
         end else begin
            idx_in = idx_ff + sss_pkg::CNT_W'(2);
         end
      end
      if (cmd.rd_a) begin
         a_in = rd_data_ff;
      end
      if (cmd.cmp_wr_a) begin
         swap_in = rd_data_ff < a_ff;
      end
      if (cmd.set_clear) begin
         count_in = '0;
         min_in   = '0;
         max_in   = '0;
         sum_in   = '0;
         drop_in  = 1'b0;
      end
   end

   // pair_none: current pair's high element would fall outside the set
   assign status.pair_none = (sss_pkg::CNT_W+1)'(idx_ff) + (sss_pkg::CNT_W+1)'(1)
                             >= (sss_pkg::CNT_W+1)'(count_ff);
   // pair_last: next pair index + 1 would fall outside the set
   assign status.pair_last = (sss_pkg::CNT_W+1)'(idx_ff) + (sss_pkg::CNT_W+1)'(3)
                             >= (sss_pkg::CNT_W+1)'(count_ff);
   assign status.pass_last = (pass_ff >= count_ff);
   assign status.div_done  = (dcnt_ff == '0);

   // Restoring divider on magnitude of the sum.
   assign rem_sh  = {rem_ff[sss_pkg::CNT_W-1:0], quo_ff[sss_pkg::SUM_W-1]};
   assign rem_sub = rem_sh - (sss_pkg::CNT_W+1)'(count_ff);

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      if (cmd.med_cap) begin
         quo_in  = sum_abs;
         rem_in  = '0;
         dcnt_in = sss_pkg::DIV_CNT_W'(sss_pkg::DIV_STEPS);
      end else if (cmd.div_step) begin
         if (!rem_sub[sss_pkg::CNT_W]) begin
            rem_in = rem_sub;
            quo_in = {quo_ff[sss_pkg::SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[sss_pkg::SUM_W-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff - sss_pkg::DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         sum_ff   <= '0;
         drop_ff  <= 1'b0;
         pass_ff  <= '0;
         idx_ff   <= '0;
         dcnt_ff  <= '0;
      end else begin
         count_ff <= count_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         sum_ff   <= sum_in;
         drop_ff  <= drop_in;
         pass_ff  <= pass_in;
         idx_ff   <= idx_in;
         dcnt_ff  <= dcnt_in;
      end
      a_ff    <= a_in;
      swap_ff <= swap_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      if (cmd.med_cap) begin
         med_ff <= rd_data_ff;
         neg_ff <= sum_ff[sss_pkg::SUM_W-1];
      end
   end

   assign quo_s        = neg_ff ? sss_pkg::SUM_W'(-quo_ff) : quo_ff;
   assign min_value    = min_ff;
   assign max_value    = max_ff;
   assign mean_value   = quo_s[31:0];
   assign median_value = med_ff;
   assign sample_count = sss_pkg::OUT_CNT_W'(count_ff);
   assign overflow     = drop_ff;

endmodule

FILE: hw/rtl/sss_control.sv
// Controller: sequences load, sort passes, median read and division.
module sss_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  sss_pkg::status_type status,
   output sss_pkg::cmd_type    cmd
);

   sss_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sss_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         sss_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take_sample = 1'b1;
               if (req_tlast) begin
                  cmd.pass_init = 1'b1;
                  state_in      = sss_pkg::ST_SORT_RD_A;
               end
            end
         end
         sss_pkg::ST_SORT_RD_A: begin
            // idx points at low element; memory read issued here
            if (status.pass_last) begin
               state_in = sss_pkg::ST_MED_RD;
            end else if (status.pair_none) begin
               // skip a pass start with no pair inside the set
               cmd.pass_next = 1'b1;
            end else begin
               state_in = sss_pkg::ST_SORT_RD_B;
            end
         end
         sss_pkg::ST_SORT_RD_B: begin
            cmd.rd_a = 1'b1;
            cmd.rd_b = 1'b1;
            state_in = sss_pkg::ST_SORT_CMP;
         end
         sss_pkg::ST_SORT_CMP: begin
            cmd.cmp_wr_a = 1'b1;
            state_in     = sss_pkg::ST_SORT_WR_B;
         end
         sss_pkg::ST_SORT_WR_B: begin
            cmd.wr_b      = 1'b1;
            cmd.pass_next = 1'b1;
            state_in      = sss_pkg::ST_SORT_RD_A;
         end
         sss_pkg::ST_MED_RD: begin
            cmd.med_rd = 1'b1;
            state_in   = sss_pkg::ST_MED_WAIT;
         end
         sss_pkg::ST_MED_WAIT: begin
            cmd.med_cap = 1'b1;
            state_in    = sss_pkg::ST_DIV;
         end
         sss_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = sss_pkg::ST_OUT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         sss_pkg::ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.set_clear = 1'b1;
               state_in      = sss_pkg::ST_LOAD;
            end
         end
         default: state_in = sss_pkg::ST_LOAD;
      endcase
   end

endmodule

FILE: hw/rtl/sample_set_statistics.sv
// Top level: min, max, mean and median over a marked set of Q16.16 samples.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: sample[31:0]; tlast: is_last
//  rsp     | out | rsp_tvalid/tready    | tdata: min,max,mean,median,count,overflow
//
// Samples load one per cycle while the set is loading, into a 1024-entry
// memory. After the marked sample an odd-even transposition sort runs count
// passes of about count/2 pairs, each pair read, compared and written back,
// then one median read and a 43-step restoring divide for the mean.
// Reset is synchronous, active high; the memory is not cleared.
// The result waits in its register until rsp_tready; no sample is taken
// while a set is being worked on.
module sample_set_statistics (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // sample[31:0]
   input  logic          req_tlast,   // is_last
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [143:0]  rsp_tdata    // min[31:0], max[63:32], mean[95:64],
                                      // median[127:96], sample_count[138:128],
                                      // overflow[139], zero fill[143:140]
);

   sss_pkg::cmd_type    cmd;
   sss_pkg::status_type status;
   logic signed [31:0]  min_value, max_value, mean_value, median_value;
   logic [sss_pkg::OUT_CNT_W-1:0] sample_count;
   logic                overflow;

   sss_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sss_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .sample       (req_tdata),
      .min_value    (min_value),
      .max_value    (max_value),
      .mean_value   (mean_value),
      .median_value (median_value),
      .sample_count (sample_count),
      .overflow     (overflow)
   );

   assign rsp_tdata = {4'b0000, overflow, sample_count, median_value,
                       mean_value, max_value, min_value};

endmodule
